>>> hdl/crb_pkg.sv
package crb_pkg;

   localparam int ROM_ADDR_BITS_DEF = 16;
   localparam int BUS_ADDR_BITS     = 25;
   localparam int ROM_SIZE_BITS     = 17;
   localparam int LANES             = 4;

   localparam logic [ROM_SIZE_BITS-1:0] ROM_SIZE_RESET = 17'h10000;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] WIDTH_BYTE = 2'd0;
   localparam logic [1:0] WIDTH_HALF = 2'd1;

   typedef enum logic [2:0] {
      SZ_BYTE = 3'b001,
      SZ_HALF = 3'b010,
      SZ_WORD = 3'b100
   } size_type;

   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_lane;
   } store_ctrl_type;

endpackage

>>> hdl/cartridge_rom_bus_reader.sv
// channel | ports                                  | transfer
// --------+----------------------------------------+----------------------------------
// request | req_op/access_width/address/load_byte  | start high and busy low
// result  | rsp_read_data, rsp_beyond_rom          | rsp_valid high, one cycle only
// config  | csr_rom_size                           | csr_valid and csr_ready high
//
// one item per cycle while busy is low; a read result appears in the cycle after its
// request transfer, set by the registered read of the byte banks. loads give no result.
// after reset busy stays high while the clear sweep zeroes one row of all four banks
// per cycle; config writes are taken throughout.
// the receiver cannot stall, so busy is high only during the clear sweep.
module cartridge_rom_bus_reader #(
   parameter int ROM_ADDR_BITS = crb_pkg::ROM_ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [1:0]                         req_access_width,
   input  logic [31:0]                        req_address,
   input  logic [7:0]                         req_load_byte,
   output logic                               rsp_valid,
   output logic [31:0]                        rsp_read_data,
   output logic                               rsp_beyond_rom,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crb_pkg::ROM_SIZE_BITS-1:0]  csr_rom_size
);
   import crb_pkg::*;

   localparam int ROW_BITS = ROM_ADDR_BITS - 2;

   logic [ROM_SIZE_BITS-1:0] rom_size_ff, rom_size_in;

   logic                     accept;
   logic [BUS_ADDR_BITS-1:0] addr_masked;
   logic [BUS_ADDR_BITS-1:0] addr_aligned;
   logic [15:0]              half;
   size_type                 size;
   logic                     beyond;
   logic [31:0]              open_data;
   store_ctrl_type           ctrl;
   logic [3:0][7:0]          rd_data;
   logic                     clearing;

   logic        pend_ff, pend_in;
   size_type    size_ff, size_in;
   logic [1:0]  lane_ff, lane_in;
   logic        beyond_ff, beyond_in;
   logic [31:0] open_ff, open_in;

   assign csr_ready   = 1'b1;
   assign busy        = clearing;
   assign accept      = start && !busy;
   assign addr_masked = req_address[BUS_ADDR_BITS-1:0];

   always_comb begin
      rom_size_in = rom_size_ff;
      if (csr_valid && csr_ready) begin
         rom_size_in = csr_rom_size;
      end
   end

   always_comb begin
      case (req_access_width)
         WIDTH_BYTE: size = SZ_BYTE;
         WIDTH_HALF: size = SZ_HALF;
         default:    size = SZ_WORD;
      endcase
   end

   always_comb begin
      addr_aligned = addr_masked;
      case (size)
         SZ_HALF: addr_aligned[0]   = 1'b0;
         SZ_WORD: addr_aligned[1:0] = 2'b00;
         default: addr_aligned      = addr_masked;
      endcase
      beyond = addr_aligned >= BUS_ADDR_BITS'(rom_size_ff);
      // open bus repeats every 128 KiB: halfword from address bits 16..1
      half = addr_aligned[16:1];
      case (size)
         SZ_BYTE: open_data = {24'h0, addr_aligned[0] ? half[15:8] : half[7:0]};
         SZ_HALF: open_data = {16'h0, half};
         default: open_data = {half, half};
      endcase
   end

   assign ctrl.wr_en   = accept && req_op == OP_LOAD;
   assign ctrl.wr_lane = addr_masked[1:0];

   crb_store #(
      .ROW_BITS (ROW_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .wr_row   (addr_masked[ROM_ADDR_BITS-1:2]),
      .wr_data  (req_load_byte),
      .rd_row   (addr_aligned[ROM_ADDR_BITS-1:2]),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   always_comb begin
      pend_in   = accept && req_op == OP_READ;
      size_in   = size;
      lane_in   = addr_aligned[1:0];
      beyond_in = beyond;
      open_in   = open_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_ff <= ROM_SIZE_RESET;
         pend_ff     <= 1'b0;
      end else begin
         rom_size_ff <= rom_size_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff   <= size_in;
      lane_ff   <= lane_in;
      beyond_ff <= beyond_in;
      open_ff   <= open_in;
   end

   always_comb begin
      case (size_ff)
         SZ_BYTE: rsp_read_data = {24'h0, rd_data[lane_ff]};
         SZ_HALF: rsp_read_data = lane_ff[1] ? {16'h0, rd_data[3], rd_data[2]}
                                             : {16'h0, rd_data[1], rd_data[0]};
         default: rsp_read_data = rd_data;
      endcase
      if (beyond_ff) begin
         rsp_read_data = open_ff;
      end
   end

   assign rsp_valid      = pend_ff;
   assign rsp_beyond_rom = beyond_ff;

   property p_rsp_from_read;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> $past(start && !busy && req_op == OP_READ);
   endproperty
   a_rsp_from_read: assert property (p_rsp_from_read) else $error("result without read");

   property p_read_gets_rsp;
      @(posedge clock) disable iff (reset)
         start && !busy && req_op == OP_READ |=> rsp_valid;
   endproperty
   a_read_gets_rsp: assert property (p_read_gets_rsp) else $error("read result lost");

   property p_busy_after_reset;
      @(posedge clock) $fell(reset) |-> busy && !rsp_valid;
   endproperty
   a_busy_after_reset: assert property (p_busy_after_reset) else $error("not clearing after reset");

endmodule

>>> hdl/crb_store.sv
module crb_store #(
   parameter int ROW_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  crb_pkg::store_ctrl_type  ctrl,
   input  logic [ROW_BITS-1:0]      wr_row,
   input  logic [7:0]               wr_data,
   input  logic [ROW_BITS-1:0]      rd_row,
   output logic [3:0][7:0]          rd_data,
   output logic                     clearing
);
   import crb_pkg::*;

   logic                clearing_ff, clearing_in;
   logic [ROW_BITS-1:0] clear_row_ff, clear_row_in;

   always_comb begin
      clearing_in  = clearing_ff;
      clear_row_in = clear_row_ff;
      if (clearing_ff) begin
         clear_row_in = clear_row_ff + ROW_BITS'(1);
         if (&clear_row_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_row_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_row_ff <= clear_row_in;
      end
   end

   assign clearing = clearing_ff;

   // one byte-wide bank per lane, so any aligned access sits in one row
   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [7:0] mem [2**ROW_BITS];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (clearing_ff) begin
            mem[clear_row_ff] <= '0;
         end else if (ctrl.wr_en && ctrl.wr_lane == 2'(b)) begin
            mem[wr_row] <= wr_data;
         end
         rd_ff <= mem[rd_row];
      end

      assign rd_data[b] = rd_ff;
   end

   property p_clear_advances;
      @(posedge clock) disable iff (reset)
         clearing_ff && !(&clear_row_ff) |=>
            clearing_ff && clear_row_ff == $past(clear_row_ff) + ROW_BITS'(1);
   endproperty
   a_clear_advances: assert property (p_clear_advances) else $error("clear sweep skipped a row");

   property p_clear_ends;
      @(posedge clock) disable iff (reset)
         clearing_ff && (&clear_row_ff) |=> !clearing_ff;
   endproperty
   a_clear_ends: assert property (p_clear_ends) else $error("clear sweep did not end");

   property p_no_write_while_clearing;
      @(posedge clock) disable iff (reset)
         clearing_ff |-> !ctrl.wr_en;
   endproperty
   a_no_write_while_clearing: assert property (p_no_write_while_clearing)
      else $error("load during clear sweep");

endmodule
